// ===== design/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; every module of the scanner imports this package.
`default_nettype none
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int PATTERN_CAP = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
    localparam int WIN_DEPTH   = MAX_PATTERN - 1;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_CARE_MASK    = 3'd2,
        CFG_PATTERN_LEN  = 3'd3,
        CFG_REGION_BASE  = 3'd4,
        CFG_REPORT_MODE  = 3'd5
    } t_cfg_idx;

    localparam logic MODE_FIRST_HIT = 1'b0;
    localparam logic MODE_ALL_HITS  = 1'b1;

    typedef struct packed {
        logic [63:0]       pattern_low_bytes;
        logic [63:0]       pattern_high_bytes;
        logic [15:0]       care_mask;
        logic [LEN_W-1:0]  pattern_length;
        logic [ADDR_W-1:0] region_base;
        logic              report_mode;
    } t_cfg;

    typedef struct packed {
        logic                   hit;
        logic                   region_start;
        logic                   region_done;
        logic [OFFSET_BITS-1:0] start_offset;
    } t_item;

endpackage
`default_nettype wire

// ===== design/mbps_cfg_regs.sv =====
// Configuration register file of the scanner: decodes indexed writes.
// Depends on mbps_pkg.
`default_nettype none
module mbps_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0] i_wr_idx,
    input  wire logic [63:0]                    i_wr_data,
    output mbps_pkg::t_cfg                      o_cfg
);
    import mbps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            case (i_wr_idx)
                CFG_PATTERN_LOW:  r_cfg.pattern_low_bytes  <= i_wr_data;
                CFG_PATTERN_HIGH: r_cfg.pattern_high_bytes <= i_wr_data;
                CFG_CARE_MASK:    r_cfg.care_mask          <= i_wr_data[15:0];
                CFG_PATTERN_LEN:  r_cfg.pattern_length     <= i_wr_data[LEN_W-1:0];
                CFG_REGION_BASE:  r_cfg.region_base        <= i_wr_data[ADDR_W-1:0];
                CFG_REPORT_MODE:  r_cfg.report_mode        <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== design/mbps_front.sv =====
// Front end of the scanner: byte window, region offset and masked compare.
// Depends on mbps_pkg; emits one classified item per accepted byte.
`default_nettype none
module mbps_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mbps_pkg::t_cfg i_cfg,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_region_start,
    input  wire logic           i_region_end,
    output mbps_pkg::t_item     o_item
);
    import mbps_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    logic [7:0]               r_win [WIN_DEPTH];
    logic [7:0]               n_win [WIN_DEPTH];
    logic [OFFSET_BITS-1:0]   r_offset;
    logic [OFFSET_BITS-1:0]   n_offset;

    logic [MAX_PATTERN*8-1:0] cand;
    logic [OFFSET_BITS-1:0]   eff_offset;
    logic [127:0]             pattern;
    logic [LEN_W-1:0]         len_m1;
    logic                     len_ok;
    logic                     reach_ok;
    logic                     mismatch;
    logic                     hit;

    assign eff_offset = i_region_start ? '0 : r_offset;
    assign pattern    = {i_cfg.pattern_high_bytes, i_cfg.pattern_low_bytes};
    assign len_m1     = i_cfg.pattern_length - LEN_W'(1);
    assign len_ok     = (i_cfg.pattern_length != '0) &&
                        (i_cfg.pattern_length <= LEN_W'(PATTERN_CAP));
    assign reach_ok   = (eff_offset != OFFSET_MAX) &&
                        (eff_offset >= OFFSET_BITS'(len_m1));

    always_comb begin
        cand[7:0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            cand[k*8 +: 8] = i_region_start ? 8'h00 : r_win[k-1];
        end
    end

    always_comb begin
        logic [IDX_W-1:0] idx;
        idx      = '0;
        mismatch = 1'b0;
        for (int j = 0; j < PATTERN_CAP; j++) begin
            idx = len_m1[IDX_W-1:0] - IDX_W'(j);
            if ((LEN_W'(j) < i_cfg.pattern_length) && i_cfg.care_mask[j] &&
                (cand[idx*8 +: 8] != pattern[j*8 +: 8])) begin
                mismatch = 1'b1;
            end
        end
    end

    assign hit = len_ok && (i_cfg.region_base != '0) && reach_ok && !mismatch;

    always_comb begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
            n_win[k] = i_region_end ? 8'h00 : cand[k*8 +: 8];
        end
        if (i_region_end) begin
            n_offset = '0;
        end else if (eff_offset == OFFSET_MAX) begin
            n_offset = OFFSET_MAX;
        end else begin
            n_offset = eff_offset + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_win[k] <= 8'h00;
            end
            r_offset <= '0;
        end else if (i_accept) begin
            r_win    <= n_win;
            r_offset <= n_offset;
        end
    end

    assign o_item.hit          = hit;
    assign o_item.region_start = i_region_start;
    assign o_item.region_done  = i_region_end;
    assign o_item.start_offset = eff_offset - OFFSET_BITS'(len_m1);

endmodule
`default_nettype wire

// ===== design/mbps_queue.sv =====
// Short item queue between the scanner front and back ends.
// Depends on mbps_pkg for the item type and depth.
`default_nettype none
module mbps_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mbps_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output mbps_pkg::t_item      o_item
);
    import mbps_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/mbps_back.sv =====
// Back end of the scanner: address add, first-hit tracking, result register.
// Depends on mbps_pkg; drains items from mbps_queue.
`default_nettype none
module mbps_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mbps_pkg::t_cfg              i_cfg,
    input  wire logic                        i_empty,
    input  wire mbps_pkg::t_item             i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [mbps_pkg::ADDR_W-1:0]      o_match_address,
    output logic                             o_found,
    output logic                             o_region_done
);
    import mbps_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_address;
    logic              r_found;
    logic              r_done;
    logic              r_hit_seen;
    logic [ADDR_W-1:0] r_first_addr;

    logic [ADDR_W-1:0] hit_addr;
    logic              seen_eff;
    logic [ADDR_W-1:0] first_eff;
    logic              n_seen;
    logic [ADDR_W-1:0] n_first;
    logic              emit;
    logic [ADDR_W-1:0] res_address;
    logic              res_found;

    assign o_pop     = !i_empty && (!r_valid || i_ready);
    assign hit_addr  = i_cfg.region_base + ADDR_W'(i_item.start_offset);
    assign seen_eff  = i_item.region_start ? 1'b0 : r_hit_seen;
    assign first_eff = i_item.region_start ? '0 : r_first_addr;
    assign n_seen    = seen_eff || i_item.hit;
    assign n_first   = (!seen_eff && i_item.hit) ? hit_addr : first_eff;
    assign emit      = i_item.region_done ||
                       ((i_cfg.report_mode == MODE_ALL_HITS) && i_item.hit);

    always_comb begin
        if (i_item.region_done && (i_cfg.report_mode == MODE_FIRST_HIT)) begin
            res_found   = n_seen;
            res_address = n_seen ? n_first : '0;
        end else begin
            res_found   = i_item.hit;
            res_address = i_item.hit ? hit_addr : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_hit_seen   <= 1'b0;
            r_first_addr <= '0;
        end else begin
            if (o_pop) begin
                r_valid      <= emit;
                r_hit_seen   <= i_item.region_done ? 1'b0 : n_seen;
                r_first_addr <= i_item.region_done ? '0 : n_first;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_address <= res_address;
            r_found   <= res_found;
            r_done    <= i_item.region_done;
        end
    end

    assign o_valid         = r_valid;
    assign o_match_address = r_address;
    assign o_found         = r_found;
    assign o_region_done   = r_done;

endmodule
`default_nettype wire

// ===== design/masked_byte_pattern_scanner_top.sv =====
// Top level of the masked byte pattern scanner.
// Depends on mbps_pkg, mbps_cfg_regs, mbps_front, mbps_queue and mbps_back.
//
//   channel  dir  handshake                  payload
//   s_axis   in   s_axis_tvalid/tready       tdata data_byte, tuser region_start,
//                                            tlast region_end
//   m_axis   out  m_axis_tvalid/tready       tdata match_address, tuser found,
//                                            tlast region_done
//   cfg      in   i_cfg_valid/o_cfg_ready    i_cfg_addr index, i_cfg_wdata value
//
// One byte per cycle while the queue is not full; results are queued, then registered.
// The compare and offset update run in the front stage, the address add in the back.
// A four-entry queue between them absorbs m_axis stalls; s_axis_tready drops when full.
// Reset is synchronous and active low; it clears control registers and the window.
`default_nettype none
module masked_byte_pattern_scanner_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  wire logic                           s_axis_tuser,  // [0] region_start
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [mbps_pkg::ADDR_W-1:0]         m_axis_tdata,  // [63:0] match_address
    output logic                                m_axis_tuser,  // [0] found
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [63:0]                    i_cfg_wdata
);
    import mbps_pkg::*;

    t_cfg  cfg;
    t_item front_item;
    t_item queue_item;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  in_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && !q_full;

    mbps_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_idx  (i_cfg_addr),
        .i_wr_data (i_cfg_wdata),
        .o_cfg     (cfg)
    );

    mbps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (in_accept),
        .i_data_byte    (s_axis_tdata),
        .i_region_start (s_axis_tuser),
        .i_region_end   (s_axis_tlast),
        .o_item         (front_item)
    );

    mbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (queue_item)
    );

    mbps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_empty         (q_empty),
        .i_item          (queue_item),
        .o_pop           (q_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_match_address (m_axis_tdata),
        .o_found         (m_axis_tuser),
        .o_region_done   (m_axis_tlast)
    );

endmodule
`default_nettype wire
